FILE: src/jcpt_pkg.sv
// ----------------------------------------------------------------------------
// jcpt_pkg
// Shared types, constants and functions of the joint center probe trajectory.
// ----------------------------------------------------------------------------
package jcpt_pkg;

   // Q.30 angle constants and CORDIC gain
   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam int unsigned        CORDIC_STEPS = 30;

   // Configuration register indexes
   localparam logic [1:0] CSR_PERIOD = 2'd0;
   localparam logic [1:0] CSR_LEG    = 2'd1;
   localparam logic [1:0] CSR_CHAIN  = 2'd2;
   localparam logic [1:0] CSR_SWEEP  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD_GO,
      ST_MOD_WAIT,
      ST_MUL_THETA,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_COS_GO,
      ST_COS_WAIT,
      ST_MUL_S,
      ST_SIN_GO,
      ST_SIN_WAIT,
      ST_MUL_D,
      ST_DONE
   } state_type;

   // Truncated Q.30 arctangent of 2^-i
   function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
      logic signed [33:0] v;
      unique case (idx)
         5'd0:  v = 34'sh03243F6A8;
         5'd1:  v = 34'sh01DAC6705;
         5'd2:  v = 34'sh00FADBAFC;
         5'd3:  v = 34'sh007F56EA6;
         5'd4:  v = 34'sh003FEAB76;
         5'd5:  v = 34'sh001FFD55B;
         5'd6:  v = 34'sh000FFFAAA;
         5'd7:  v = 34'sh0007FFF55;
         5'd8:  v = 34'sh0003FFFEA;
         5'd9:  v = 34'sh0001FFFFD;
         5'd10: v = 34'sh0000FFFFF;
         5'd11: v = 34'sh00007FFFF;
         5'd12: v = 34'sh00003FFFF;
         5'd13: v = 34'sh00001FFFF;
         5'd14: v = 34'sh00000FFFF;
         5'd15: v = 34'sh000007FFF;
         5'd16: v = 34'sh000003FFF;
         5'd17: v = 34'sh000001FFF;
         5'd18: v = 34'sh000000FFF;
         5'd19: v = 34'sh0000007FF;
         5'd20: v = 34'sh0000003FF;
         5'd21: v = 34'sh0000001FF;
         5'd22: v = 34'sh0000000FF;
         5'd23: v = 34'sh00000007F;
         5'd24: v = 34'sh00000003F;
         5'd25: v = 34'sh00000001F;
         5'd26: v = 34'sh00000000F;
         5'd27: v = 34'sh000000008;
         5'd28: v = 34'sh000000004;
         5'd29: v = 34'sh000000002;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -35'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: src/joint_center_probe_trajectory.sv
// ----------------------------------------------------------------------------
// joint_center_probe_trajectory
// Probe sweep setpoint generator: two axes of one leg follow a cosine-shaped
// phase around a base position latched at tick zero.
// ----------------------------------------------------------------------------
// One transaction at a time: req_tready is high only while the sequencer is
//   idle; a serial divider and two CORDIC passes share one sequencer.
// A finished result waits in the rsp register while the next req is taken.
// Reset: synchronous, active high; registers to their defaults, base
//   positions to zero, sequencer to idle.
module joint_center_probe_trajectory import jcpt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: tick_count[16:0], feedback_a[48:17], feedback_b[80:49],
   //            feedback_c[112:81], zero pad[119:113]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,
   // rsp_tdata: first_motor[3:0], setpoint_a[35:4], setpoint_b[67:36],
   //            setpoint_c[99:68], ticks_left[117:100], zero pad[119:118]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   // ---------------------------------------------------------------- config
   logic [15:0]        period_ff;
   logic [2:0]         leg_ff;
   logic [1:0]         chain_ff;
   logic signed [31:0] sweep_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 16'd1;
         leg_ff    <= '0;
         chain_ff  <= '0;
         sweep_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PERIOD: period_ff <= csr_data[15:0];
            CSR_LEG:    leg_ff    <= csr_data[2:0];
            CSR_CHAIN:  chain_ff  <= csr_data[1:0];
            CSR_SWEEP:  sweep_ff  <= csr_data;
            default:    ;
         endcase
      end
   end

   // Zero period acts as one
   logic [15:0] period_eff;
   assign period_eff = (period_ff == 16'd0) ? 16'd1 : period_ff;

   // ---------------------------------------------------------------- input
   state_type          state_ff, state_in;
   logic               req_accept;
   logic [16:0]        count_ff;
   logic signed [31:0] base_ff [3];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Latch the count; tick zero also latches the base positions
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff[0] <= '0;
         base_ff[1] <= '0;
         base_ff[2] <= '0;
      end else if (req_accept && (req_tdata[16:0] == 17'd0)) begin
         base_ff[0] <= req_tdata[48:17];
         base_ff[1] <= req_tdata[80:49];
         base_ff[2] <= req_tdata[112:81];
      end
      if (req_accept) begin
         count_ff <= req_tdata[16:0];
      end
   end

   // ---------------------------------------------------------------- units
   logic        div_start, div_done;
   logic [5:0]  div_steps;
   logic [47:0] div_dividend;
   logic [15:0] div_rem;
   logic [31:0] div_quo;

   jcpt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .steps     (div_steps),
      .dividend  (div_dividend),
      .divisor   (period_eff),
      .done      (div_done),
      .remainder (div_rem),
      .quotient  (div_quo)
   );

   logic               cor_start, cor_done;
   logic signed [33:0] cor_angle, cor_sine;

   jcpt_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .angle (cor_angle),
      .done  (cor_done),
      .sine  (cor_sine)
   );

   // Shared multiplier with a registered product
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff;
   logic               mul_en;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // ---------------------------------------------------------------- angles
   logic signed [33:0] s_val, r_raw, r_fold, theta_z, delta;

   // theta - PI/2 feeds the cosine pass
   assign theta_z = $signed({2'b00, div_quo}) - HALF_PI_Q30;
   // s = PI - PI*cos(theta)
   assign s_val   = PI_Q30 - prod_ff[63:30];
   assign r_raw   = s_val - PI_Q30;

   // Fold r into [-PI/2, PI/2]
   always_comb begin
      priority if (r_raw > HALF_PI_Q30) begin
         r_fold = PI_Q30 - r_raw;
      end else if (r_raw < -HALF_PI_Q30) begin
         r_fold = -PI_Q30 - r_raw;
      end else begin
         r_fold = r_raw;
      end
   end

   assign delta = prod_ff[63:30];

   // ---------------------------------------------------------------- sequencer
   logic rsp_load;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_accept) state_in = ST_MOD_GO;
         ST_MOD_GO:    state_in = ST_MOD_WAIT;
         ST_MOD_WAIT:  if (div_done) state_in = ST_MUL_THETA;
         ST_MUL_THETA: state_in = ST_DIV_GO;
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (div_done) state_in = ST_COS_GO;
         ST_COS_GO:    state_in = ST_COS_WAIT;
         ST_COS_WAIT:  if (cor_done) state_in = ST_MUL_S;
         ST_MUL_S:     state_in = ST_SIN_GO;
         ST_SIN_GO:    state_in = ST_SIN_WAIT;
         ST_SIN_WAIT:  if (cor_done) state_in = ST_MUL_D;
         ST_MUL_D:     state_in = ST_DONE;
         ST_DONE:      if (rsp_load) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      div_steps    = 6'd48;
      div_dividend = prod_ff[47:0];
      cor_start    = 1'b0;
      cor_angle    = theta_z;
      mul_en       = 1'b0;
      mul_a        = PI_Q30;
      mul_b        = '0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_MOD_GO: begin
            // p = count mod N, count aligned to the top of the dividend
            div_start    = 1'b1;
            div_steps    = 6'd17;
            div_dividend = {count_ff, 31'd0};
         end
         ST_MUL_THETA: begin
            mul_en = 1'b1;
            mul_b  = $signed({18'd0, div_rem}) + 34'sd1;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
         end
         ST_COS_GO: begin
            cor_start = 1'b1;
         end
         ST_MUL_S: begin
            mul_en = 1'b1;
            mul_b  = -cor_sine;
         end
         ST_SIN_GO: begin
            cor_start = 1'b1;
            cor_angle = r_fold;
         end
         ST_MUL_D: begin
            mul_en = 1'b1;
            mul_a  = 34'(sweep_ff);
            mul_b  = -cor_sine;
         end
         ST_DONE: begin
            rsp_load = !rsp_tvalid || rsp_tready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- result
   logic [1:0]         ax1, ax2;
   logic               first_half;
   logic [2:0]         leg_sat;
   logic [3:0]         first_motor;
   logic [17:0]        ticks_left;
   logic signed [34:0] delta_w;
   logic signed [34:0] add_k [3];
   logic signed [31:0] setp [3];

   // Axes swept for each chain; chain three behaves as chain zero
   always_comb begin
      unique case (chain_ff)
         2'd1:    begin ax1 = 2'd2; ax2 = 2'd0; end
         2'd2:    begin ax1 = 2'd0; ax2 = 2'd1; end
         default: begin ax1 = 2'd1; ax2 = 2'd2; end
      endcase
   end

   assign first_half  = {1'b0, count_ff} < {2'b00, period_eff};
   assign leg_sat     = (leg_ff > 3'd5) ? 3'd5 : leg_ff;
   assign first_motor = 4'({1'b0, leg_sat} + {leg_sat, 1'b0});
   assign ticks_left  = {1'b0, period_eff, 1'b0} - {1'b0, count_ff} - 18'd1;
   assign delta_w     = 35'(delta);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (2'(k) == ax1) begin
            add_k[k] = delta_w;
         end else if (2'(k) == ax2) begin
            add_k[k] = first_half ? delta_w : -delta_w;
         end else begin
            add_k[k] = '0;
         end
         setp[k] = sat32(35'(base_ff[k]) + add_k[k]);
      end
   end

   logic         rsp_valid_ff, rsp_valid_in;
   logic [119:0] rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= {2'b00, ticks_left, setp[2], setp[1], setp[0], first_motor};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   // Divider finishes only while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MOD_WAIT || state_ff == ST_DIV_WAIT))
      else $error("divider done outside a divide wait");

   // CORDIC finishes only while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == ST_COS_WAIT || state_ff == ST_SIN_WAIT))
      else $error("cordic done outside a trig wait");

   // Hold off new transactions once one is taken
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("req taken while busy");

   // A result is only loaded where it cannot overwrite a pending one
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("pending rsp overwritten");

endmodule

FILE: src/jcpt_div.sv
// ----------------------------------------------------------------------------
// jcpt_div
// Restoring radix-2 divider, one quotient bit per cycle, 48-bit dividend
// taken from the top, 16-bit divisor.
// ----------------------------------------------------------------------------
module jcpt_div import jcpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [5:0]  steps,
   input  logic [47:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] remainder,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] num_ff, num_in;
   logic [15:0] rem_ff, rem_in;
   logic [16:0] trial;
   logic [16:0] diff;
   logic        ge;

   assign trial = {rem_ff, num_ff[47]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};
   assign done  = busy_ff && (cnt_ff == 6'd1);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         num_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         rem_in  = ge ? diff[15:0] : trial[15:0];
         num_in  = {num_ff[46:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         busy_in = !done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;
   assign quotient  = num_ff[31:0];

endmodule

FILE: src/jcpt_cordic.sv
// ----------------------------------------------------------------------------
// jcpt_cordic
// Rotation-mode CORDIC sine, one micro-rotation per cycle, Q.30.
// ----------------------------------------------------------------------------
module jcpt_cordic import jcpt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [33:0] angle,
   output logic               done,
   output logic signed [33:0] sine
);

   logic               busy_ff, busy_in;
   logic [4:0]         idx_ff, idx_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic signed [33:0] dx, dy;

   assign dx   = y_ff >>> idx_ff;
   assign dy   = x_ff >>> idx_ff;
   assign done = busy_ff && (idx_ff == 5'(CORDIC_STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = angle;
      end else if (busy_ff) begin
         // rotate toward zero residual angle
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_q30(idx_ff);
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_q30(idx_ff);
         end
         idx_in  = idx_ff + 5'd1;
         busy_in = !done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign sine = y_ff;

endmodule
